@@ design/sam_pkg.sv @@
package sam_pkg;

    localparam int MAX_TEXT  = 256;
    localparam int SYM_W     = 8;
    localparam int ALPHA     = 1 << SYM_W;
    localparam int MAX_NODES = 2 * MAX_TEXT;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int LEN_W     = $clog2(MAX_TEXT + 1);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int TADDR_W   = NODE_W + SYM_W;
    localparam int TDEPTH    = MAX_NODES * ALPHA;
    localparam int IN_SYM_W  = 8;
    localparam int POS_W     = 8;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_PATTERN = 2'd2,
        CMD_EMPTY   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_ZERO,
        ST_IDLE,
        ST_PCHK,
        ST_PFE,
        ST_RES,
        ST_WRD,
        ST_WCHK,
        ST_WQ,
        ST_COPY,
        ST_RRD,
        ST_RCHK,
        ST_FINQ,
        ST_FINC,
        ST_FINL
    } t_state;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [NODE_W-1:0] link;
        logic [LEN_W-1:0]  fe;
    } t_node;

    localparam int NODE_REC_W = $bits(t_node);

endpackage

@@ design/sam_in_if.sv @@
interface sam_in_if;
    import sam_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          command;
    logic [IN_SYM_W-1:0] symbol;
    logic                last;

    modport source (output valid, command, symbol, last, input ready);
    modport sink   (input valid, command, symbol, last, output ready);
endinterface

@@ design/sam_out_if.sv @@
interface sam_out_if;
    import sam_pkg::*;
    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] first_position;
    logic             overflow;

    modport source (output valid, found, first_position, overflow, input ready);
    modport sink   (input valid, found, first_position, overflow, output ready);
endinterface

@@ design/sam_ram.sv @@
module sam_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] mem [D];
    logic [W-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/suffix_automaton_matcher.sv @@
// Suffix automaton substring matcher. Text symbols (append) build the automaton
// online; pattern symbols walk it from the root and the symbol marked last returns
// found and the start index of the first occurrence. Transitions live in one
// synchronous RAM of MAX_NODES x ALPHA entries, node records (length, suffix link,
// first end) in a second RAM. A pattern symbol reads its transition and checks it;
// the one marked last also reads the node record on a hit, then loads the result
// register, which waits while an earlier result is still held. After a failed match
// symbols are absorbed without a lookup and the last one reports a miss.
// An empty query goes straight to the result. An append first clears the new
// node's transition row, then walks suffix links adding transitions, reads the
// target node, and when a node is split, copies its row into the clone, redirects
// links to the clone and updates the node records. A dropped append only sets the
// overflow bit. A clear wipes the root row; after reset the same root row wipe runs
// before the first transaction is taken.
// Text beyond MAX_TEXT symbols is dropped and sets a sticky overflow bit.
module suffix_automaton_matcher
    import sam_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    sam_in_if.sink    i_item,
    sam_out_if.source o_result
);

    t_state r_state, n_state;

    logic [NODE_W-1:0] r_last, n_last;
    logic [LEN_W-1:0]  r_last_len, n_last_len;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [NODE_W-1:0] r_mnode, n_mnode;
    logic [LEN_W-1:0]  r_mlen, n_mlen;
    logic              r_mfail, n_mfail;
    logic              r_ovf, n_ovf;
    logic [SYM_W-1:0]  r_sym, n_sym;
    logic              r_plast, n_plast;
    logic [NODE_W-1:0] r_cur, n_cur;
    logic [LEN_W-1:0]  r_cur_len, n_cur_len;
    logic [NODE_W-1:0] r_p, n_p;
    logic [LEN_W-1:0]  r_lenp, n_lenp;
    logic [NODE_W-1:0] r_q, n_q;
    t_node             r_qrec, n_qrec;
    logic [NODE_W-1:0] r_clone, n_clone;
    logic [SYM_W:0]    r_idx, n_idx;
    logic [NODE_W-1:0] r_zrow, n_zrow;
    logic              r_zapp, n_zapp;
    logic              r_res_found, n_res_found;
    logic [POS_W-1:0]  r_res_pos, n_res_pos;
    logic              r_out_valid;
    logic              r_out_found;
    logic [POS_W-1:0]  r_out_pos;
    logic              r_out_ovf;

    logic               t_we;
    logic [TADDR_W-1:0] t_waddr, t_raddr;
    logic [NODE_W-1:0]  t_wdata, t_rdata;
    logic               nd_we;
    logic [NODE_W-1:0]  nd_waddr, nd_raddr;
    t_node              nd_wrec, nd_rrec;
    logic [NODE_REC_W-1:0] nd_rdata;

    logic             acc;
    logic [SYM_W-1:0] in_sym;
    logic             full;
    logic             res_load;
    logic [LEN_W-1:0] lenp_now;
    logic [LEN_W:0]   pos_calc;
    t_cmd             in_cmd;

    sam_ram #(.W(NODE_W), .D(TDEPTH)) u_trans (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    sam_ram #(.W(NODE_REC_W), .D(MAX_NODES)) u_node (
        .i_clk   (i_clk),
        .i_we    (nd_we),
        .i_waddr (nd_waddr),
        .i_wdata (nd_wrec),
        .i_raddr (nd_raddr),
        .o_rdata (nd_rdata)
    );

    assign nd_rrec = t_node'(nd_rdata);
    assign in_cmd  = t_cmd'(i_item.command);
    assign in_sym  = i_item.symbol[SYM_W-1:0];
    assign acc     = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == ST_IDLE);
    assign full = (r_last_len >= LEN_W'(MAX_TEXT)) ||
                  (({1'b0, r_count} + (CNT_W+1)'(2)) > (CNT_W+1)'(MAX_NODES));
    assign res_load = (r_state == ST_RES) && (!r_out_valid || o_result.ready);
    assign lenp_now = (r_p == '0) ? '0 : nd_rrec.len;
    assign pos_calc = {1'b0, nd_rrec.fe} + (LEN_W+1)'(1) - {1'b0, r_mlen};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ZERO: begin
                if (r_idx[SYM_W-1:0] == SYM_W'(ALPHA - 1)) begin
                    n_state = r_zapp ? ST_WRD : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (acc) begin
                    case (in_cmd)
                        CMD_CLEAR:   n_state = ST_ZERO;
                        CMD_APPEND:  n_state = full ? ST_IDLE : ST_ZERO;
                        CMD_EMPTY:   n_state = ST_RES;
                        CMD_PATTERN: begin
                            if (!r_mfail) begin
                                n_state = ST_PCHK;
                            end else if (i_item.last) begin
                                n_state = ST_RES;
                            end
                        end
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PCHK: begin
                if (!r_plast) begin
                    n_state = ST_IDLE;
                end else if (t_rdata == '0) begin
                    n_state = ST_RES;
                end else begin
                    n_state = ST_PFE;
                end
            end
            ST_PFE:  n_state = ST_RES;
            ST_RES:  n_state = res_load ? ST_IDLE : ST_RES;
            ST_WRD:  n_state = ST_WCHK;
            ST_WCHK: begin
                if (t_rdata != '0) begin
                    n_state = ST_WQ;
                end else begin
                    n_state = (r_p == '0) ? ST_FINL : ST_WRD;
                end
            end
            ST_WQ: begin
                if (({1'b0, r_lenp} + (LEN_W+1)'(1)) == {1'b0, nd_rrec.len}) begin
                    n_state = ST_FINL;
                end else begin
                    n_state = ST_COPY;
                end
            end
            ST_COPY: begin
                if (r_idx == (SYM_W+1)'(ALPHA)) begin
                    n_state = ST_RRD;
                end
            end
            ST_RRD:  n_state = ST_RCHK;
            ST_RCHK: begin
                if (t_rdata == r_q && r_p != '0) begin
                    n_state = ST_RRD;
                end else begin
                    n_state = ST_FINQ;
                end
            end
            ST_FINQ: n_state = ST_FINC;
            ST_FINC: n_state = ST_FINL;
            ST_FINL: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_last      = r_last;
        n_last_len  = r_last_len;
        n_count     = r_count;
        n_mnode     = r_mnode;
        n_mlen      = r_mlen;
        n_mfail     = r_mfail;
        n_ovf       = r_ovf;
        n_sym       = r_sym;
        n_plast     = r_plast;
        n_cur       = r_cur;
        n_cur_len   = r_cur_len;
        n_p         = r_p;
        n_lenp      = r_lenp;
        n_q         = r_q;
        n_qrec      = r_qrec;
        n_clone     = r_clone;
        n_idx       = r_idx;
        n_zrow      = r_zrow;
        n_zapp      = r_zapp;
        n_res_found = r_res_found;
        n_res_pos   = r_res_pos;
        t_we        = 1'b0;
        t_waddr     = '0;
        t_wdata     = '0;
        t_raddr     = '0;
        nd_we       = 1'b0;
        nd_waddr    = '0;
        nd_wrec     = '0;
        nd_raddr    = '0;
        case (r_state)
            ST_ZERO: begin
                // wipe one transition row
                t_we    = 1'b1;
                t_waddr = {r_zrow, r_idx[SYM_W-1:0]};
                n_idx   = r_idx + 1'b1;
            end
            ST_IDLE: begin
                if (acc) begin
                    case (in_cmd)
                        CMD_CLEAR: begin
                            n_last     = '0;
                            n_last_len = '0;
                            n_count    = CNT_W'(1);
                            n_ovf      = 1'b0;
                            n_mnode    = '0;
                            n_mlen     = '0;
                            n_mfail    = 1'b0;
                            n_zrow     = '0;
                            n_idx      = '0;
                            n_zapp     = 1'b0;
                        end
                        CMD_APPEND: begin
                            if (full) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_cur       = r_count[NODE_W-1:0];
                                n_count     = r_count + 1'b1;
                                n_cur_len   = r_last_len + 1'b1;
                                nd_we       = 1'b1;
                                nd_waddr    = r_count[NODE_W-1:0];
                                nd_wrec.len = r_last_len + 1'b1;
                                nd_wrec.link = '0;
                                nd_wrec.fe  = r_last_len;
                                n_sym       = in_sym;
                                n_p         = r_last;
                                n_zrow      = r_count[NODE_W-1:0];
                                n_idx       = '0;
                                n_zapp      = 1'b1;
                            end
                        end
                        CMD_EMPTY: begin
                            n_mnode     = '0;
                            n_mlen      = '0;
                            n_mfail     = 1'b0;
                            n_res_found = 1'b1;
                            n_res_pos   = '0;
                        end
                        CMD_PATTERN: begin
                            n_sym   = in_sym;
                            n_plast = i_item.last;
                            t_raddr = {r_mnode, in_sym};
                            if (r_mfail && i_item.last) begin
                                n_mnode     = '0;
                                n_mlen      = '0;
                                n_mfail     = 1'b0;
                                n_res_found = 1'b0;
                                n_res_pos   = '0;
                            end
                        end
                        default: begin
                            n_sym = r_sym;
                        end
                    endcase
                end
            end
            ST_PCHK: begin
                // take the transition or fail
                nd_raddr = t_rdata;
                if (t_rdata == '0) begin
                    n_mfail = 1'b1;
                end else begin
                    n_mnode = t_rdata;
                    n_mlen  = r_mlen + 1'b1;
                end
                if (r_plast && t_rdata == '0) begin
                    n_mnode     = '0;
                    n_mlen      = '0;
                    n_mfail     = 1'b0;
                    n_res_found = 1'b0;
                    n_res_pos   = '0;
                end
            end
            ST_PFE: begin
                n_res_found = 1'b1;
                n_res_pos   = pos_calc[POS_W-1:0];
                n_mnode     = '0;
                n_mlen      = '0;
                n_mfail     = 1'b0;
            end
            ST_WRD: begin
                t_raddr  = {r_p, r_sym};
                nd_raddr = r_p;
            end
            ST_WCHK: begin
                // add missing transitions along the suffix chain
                n_lenp = lenp_now;
                if (t_rdata == '0) begin
                    t_we    = 1'b1;
                    t_waddr = {r_p, r_sym};
                    t_wdata = r_cur;
                    n_p     = nd_rrec.link;
                end else begin
                    n_q      = t_rdata;
                    nd_raddr = t_rdata;
                end
            end
            ST_WQ: begin
                n_qrec = nd_rrec;
                if (({1'b0, r_lenp} + (LEN_W+1)'(1)) == {1'b0, nd_rrec.len}) begin
                    nd_we        = 1'b1;
                    nd_waddr     = r_cur;
                    nd_wrec.len  = r_cur_len;
                    nd_wrec.link = r_q;
                    nd_wrec.fe   = r_cur_len - 1'b1;
                end else begin
                    n_clone      = r_count[NODE_W-1:0];
                    n_count      = r_count + 1'b1;
                    nd_we        = 1'b1;
                    nd_waddr     = r_count[NODE_W-1:0];
                    nd_wrec.len  = r_lenp + 1'b1;
                    nd_wrec.link = nd_rrec.link;
                    nd_wrec.fe   = nd_rrec.fe;
                    n_idx        = '0;
                end
            end
            ST_COPY: begin
                // stream the original's row into the clone
                if (r_idx != (SYM_W+1)'(ALPHA)) begin
                    t_raddr = {r_q, r_idx[SYM_W-1:0]};
                end
                if (r_idx != '0) begin
                    t_we    = 1'b1;
                    t_waddr = {r_clone, SYM_W'(r_idx - 1'b1)};
                    t_wdata = t_rdata;
                end
                n_idx = r_idx + 1'b1;
            end
            ST_RRD: begin
                t_raddr  = {r_p, r_sym};
                nd_raddr = r_p;
            end
            ST_RCHK: begin
                // redirect transitions from the original to the clone
                if (t_rdata == r_q) begin
                    t_we    = 1'b1;
                    t_waddr = {r_p, r_sym};
                    t_wdata = r_clone;
                    n_p     = nd_rrec.link;
                end
            end
            ST_FINQ: begin
                nd_we        = 1'b1;
                nd_waddr     = r_q;
                nd_wrec.len  = r_qrec.len;
                nd_wrec.link = r_clone;
                nd_wrec.fe   = r_qrec.fe;
            end
            ST_FINC: begin
                nd_we        = 1'b1;
                nd_waddr     = r_cur;
                nd_wrec.len  = r_cur_len;
                nd_wrec.link = r_clone;
                nd_wrec.fe   = r_cur_len - 1'b1;
            end
            ST_FINL: begin
                n_last     = r_cur;
                n_last_len = r_cur_len;
                n_mnode    = '0;
                n_mlen     = '0;
                n_mfail    = 1'b0;
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_ZERO;
            r_last     <= '0;
            r_last_len <= '0;
            r_count    <= CNT_W'(1);
            r_mnode    <= '0;
            r_mlen     <= '0;
            r_mfail    <= 1'b0;
            r_ovf      <= 1'b0;
            r_idx      <= '0;
            r_zrow     <= '0;
            r_zapp     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_last     <= n_last;
            r_last_len <= n_last_len;
            r_count    <= n_count;
            r_mnode    <= n_mnode;
            r_mlen     <= n_mlen;
            r_mfail    <= n_mfail;
            r_ovf      <= n_ovf;
            r_idx      <= n_idx;
            r_zrow     <= n_zrow;
            r_zapp     <= n_zapp;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_sym       <= n_sym;
        r_plast     <= n_plast;
        r_cur       <= n_cur;
        r_cur_len   <= n_cur_len;
        r_p         <= n_p;
        r_lenp      <= n_lenp;
        r_q         <= n_q;
        r_qrec      <= n_qrec;
        r_clone     <= n_clone;
        r_res_found <= n_res_found;
        r_res_pos   <= n_res_pos;
    end

    // hold the result transaction until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_found <= r_res_found;
            r_out_pos   <= r_res_pos;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.found          = r_out_found;
    assign o_result.first_position = r_out_pos;
    assign o_result.overflow       = r_out_ovf;

endmodule

@@ design/sam_checker.sv @@
module sam_checker
    import sam_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic [1:0]       i_in_command,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_out_found,
    input logic [POS_W-1:0] i_out_pos
);
    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // hold a pending result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // clear always wipes the root row before taking more
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_command == CMD_CLEAR |=> !i_in_ready)
        else $error("clear did not go busy");

    // empty query answers found at position zero
    a_empty_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_command == CMD_EMPTY && !i_out_valid |->
        ##2 (i_out_valid && i_out_found && i_out_pos == '0))
        else $error("empty query result wrong");

    // a miss reports position zero
    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_found |-> i_out_pos == '0)
        else $error("miss with nonzero position");
endmodule

bind suffix_automaton_matcher sam_checker u_sam_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_in_command (i_item.command),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_found  (o_result.found),
    .i_out_pos    (o_result.first_position)
);

@@ dv/suffix_automaton_matcher_tb.sv @@
`timescale 1ns / 100ps

module suffix_automaton_matcher_tb;
    import sam_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sam_in_if  item_if ();
    sam_out_if res_if ();

    suffix_automaton_matcher uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if.sink),
        .o_result (res_if.source)
    );

    always #2 i_clk = ~i_clk;

    typedef struct packed {
        logic       found;
        logic [7:0] first_position;
        logic       overflow;
    } t_match;

    // Shadow automaton
    logic [9:0]  sa_next [MAX_NODES][ALPHA];
    logic [8:0]  sa_len  [MAX_NODES];
    int          sa_link [MAX_NODES];
    logic [8:0]  sa_fe   [MAX_NODES];
    int          sa_last;
    int          sa_count;
    int          pm_node;
    int          pm_len;
    bit          pm_failed;
    bit          sa_ovf;

    t_match      match_queue[$];
    int          error_count = 0;
    bit          hold_off = 1'b0;

    function automatic void shadow_clear();
        for (int s = 0; s < ALPHA; s++) sa_next[0][s] = '0;
        sa_len[0] = '0;
        sa_link[0] = -1;
        sa_fe[0] = '0;
        sa_last = 0;
        sa_count = 1;
        sa_ovf = 1'b0;
        pm_node = 0;
        pm_len = 0;
        pm_failed = 1'b0;
    endfunction

    function automatic void shadow_append(int s);
        int cur, p, q, cl;
        if (sa_len[sa_last] >= MAX_TEXT || sa_count + 2 > MAX_NODES) begin
            sa_ovf = 1'b1;
            return;
        end
        cur = sa_count++;
        sa_len[cur] = 9'(sa_len[sa_last] + 1);
        sa_fe[cur] = 9'(sa_len[cur] - 1);
        sa_link[cur] = 0;
        for (int k = 0; k < ALPHA; k++) sa_next[cur][k] = '0;
        p = sa_last;
        while (p != -1 && sa_next[p][s] == 0) begin
            sa_next[p][s] = 10'(cur);
            p = sa_link[p];
        end
        if (p != -1) begin
            q = int'(sa_next[p][s]);
            if (sa_len[p] + 1 == sa_len[q]) begin
                sa_link[cur] = q;
            end else begin
                cl = sa_count++;
                for (int k = 0; k < ALPHA; k++) sa_next[cl][k] = sa_next[q][k];
                sa_len[cl] = 9'(sa_len[p] + 1);
                sa_link[cl] = sa_link[q];
                sa_fe[cl] = sa_fe[q];
                while (p != -1 && sa_next[p][s] == q) begin
                    sa_next[p][s] = 10'(cl);
                    p = sa_link[p];
                end
                sa_link[q] = cl;
                sa_link[cur] = cl;
            end
        end
        sa_last = cur;
        pm_node = 0;
        pm_len = 0;
        pm_failed = 1'b0;
    endfunction

    // Advance the shadow and queue any expected match result
    function automatic void predict_match(t_cmd cmd, logic [7:0] s, logic lst);
        t_match m;
        int nx;
        case (cmd)
            CMD_CLEAR: shadow_clear();
            CMD_APPEND: shadow_append(s);
            CMD_EMPTY: begin
                pm_node = 0;
                pm_len = 0;
                pm_failed = 1'b0;
                m.found = 1'b1;
                m.first_position = '0;
                m.overflow = sa_ovf;
                match_queue = {match_queue, m};
            end
            default: begin
                if (!pm_failed) begin
                    nx = int'(sa_next[pm_node][s]);
                    if (nx == 0) pm_failed = 1'b1;
                    else begin
                        pm_node = nx;
                        pm_len++;
                    end
                end
                if (lst) begin
                    m.found = !pm_failed;
                    m.first_position = pm_failed ? 8'd0 : 8'(sa_fe[pm_node] + 1 - pm_len);
                    m.overflow = sa_ovf;
                    match_queue = {match_queue, m};
                    pm_node = 0;
                    pm_len = 0;
                    pm_failed = 1'b0;
                end
            end
        endcase
    endfunction

    // Send one transaction, with a random gap first
    task automatic send_item(t_cmd cmd, logic [7:0] s, logic lst);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid   <= 1'b1;
        item_if.command <= cmd;
        item_if.symbol  <= s;
        item_if.last    <= lst;
        do @(posedge i_clk); while (!item_if.ready);
        predict_match(cmd, s, lst);
    endtask

    task automatic send_text(int n, int alpha);
        repeat (n) send_item(CMD_APPEND, 8'($urandom_range(0, alpha - 1)), 1'b0);
    endtask

    task automatic send_pattern(int n, int alpha);
        for (int k = 0; k < n; k++)
            send_item(CMD_PATTERN, 8'($urandom_range(0, alpha - 1)), k == n - 1);
    endtask

    task automatic wait_drained();
        item_if.valid <= 1'b0;
        while (match_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Receiver: random stalls, long hold-off on request
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                res_if.ready <= 1'b0;
            end else if (res_if.valid && res_if.ready) begin
                res_if.ready <= 1'b0;
            end else if (!res_if.ready) begin
                repeat ($urandom_range(0, 6)) begin
                    @(posedge i_clk);
                end
                if (!hold_off) res_if.ready <= 1'b1;
            end
        end
    end

    // Check every result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_match e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (match_queue.size() == 0) begin
                $display("%0t unexpected result: exp none act %b/%0d/%b", $time,
                         res_if.found, res_if.first_position, res_if.overflow);
                error_count++;
            end else begin
                e = match_queue.pop_front();
                if (e.found !== res_if.found) begin
                    $display("%0t found: exp %b act %b", $time, e.found, res_if.found);
                    error_count++;
                end
                if (e.first_position !== res_if.first_position) begin
                    $display("%0t first_position: exp %0d act %0d", $time,
                             e.first_position, res_if.first_position);
                    error_count++;
                end
                if (e.overflow !== res_if.overflow) begin
                    $display("%0t overflow: exp %b act %b", $time, e.overflow,
                             res_if.overflow);
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed();
        send_item(CMD_EMPTY, 8'd0, 1'b0);
        send_item(CMD_PATTERN, 8'd0, 1'b1);
        send_item(CMD_APPEND, 8'h00, 1'b0);
        send_item(CMD_APPEND, 8'hFF, 1'b0);
        send_item(CMD_APPEND, 8'h00, 1'b0);
        send_item(CMD_APPEND, 8'hFF, 1'b1);
        send_item(CMD_APPEND, 8'h00, 1'b0);
        send_item(CMD_PATTERN, 8'hFF, 1'b0);
        send_item(CMD_PATTERN, 8'h00, 1'b1);
        // missing transition then absorbed symbols
        send_item(CMD_PATTERN, 8'h55, 1'b0);
        send_item(CMD_PATTERN, 8'h00, 1'b0);
        send_item(CMD_PATTERN, 8'hFF, 1'b1);
        // abandon pattern with append, then with empty query
        send_item(CMD_PATTERN, 8'h00, 1'b0);
        send_item(CMD_APPEND, 8'hAA, 1'b0);
        send_item(CMD_PATTERN, 8'hAA, 1'b1);
        send_item(CMD_PATTERN, 8'h00, 1'b0);
        send_item(CMD_EMPTY, 8'hFF, 1'b1);
        send_item(CMD_CLEAR, 8'hFF, 1'b1);
        send_item(CMD_PATTERN, 8'h00, 1'b1);
        wait_drained();
    endtask

    task automatic test_overflow();
        send_item(CMD_CLEAR, 8'd0, 1'b0);
        send_text(MAX_TEXT + 3, 2);
        send_pattern(3, 2);
        send_item(CMD_EMPTY, 8'd0, 1'b0);
        send_item(CMD_CLEAR, 8'd0, 1'b0);
        send_item(CMD_EMPTY, 8'd0, 1'b0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (8) send_pattern(1, 4);
        join
        wait_drained();
    endtask

    task automatic test_random();
        int alpha;
        repeat (38) begin
            alpha = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(2, 4);
            send_item(CMD_CLEAR, 8'($urandom), 1'($urandom));
            send_text($urandom_range(1, 40), alpha);
            repeat (8) begin
                case ($urandom_range(0, 9))
                    0: send_item(CMD_EMPTY, 8'($urandom), 1'($urandom));
                    1: send_item(CMD_APPEND, 8'($urandom), 1'($urandom));
                    2: send_item(CMD_PATTERN, 8'($urandom), 1'($urandom));
                    default: send_pattern($urandom_range(1, 6), alpha);
                endcase
            end
        end
        wait_drained();
    endtask

    initial begin
        item_if.valid   = 1'b0;
        item_if.command = CMD_CLEAR;
        item_if.symbol  = '0;
        item_if.last    = 1'b0;
        shadow_clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_overflow();
        test_backpressure();
        test_random();
        if (error_count == 0 && match_queue.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
